@@ hdl/assert_macros.svh @@
// Assertion macros shared by the speed loop modules.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checks that the consequent holds in the same cycle as the antecedent.
`define PIMS_ASSERT_SAME(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Checks that the consequent holds in the cycle after the antecedent.
`define PIMS_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ hdl/pims_pkg.sv @@
// Package with the widths, codes and stage types of the PI motor speed loop.
package pims_pkg;

    // Field and datapath widths.
    localparam int CMD_W      = 2;
    localparam int ARG_W      = 8;
    localparam int COUNT_W    = 16;
    localparam int ERR_W      = 17;
    localparam int INTEG_W    = 18;
    localparam int ACC_W      = 19;
    localparam int GAIN_W     = 8;
    localparam int IMAX_W     = 17;
    localparam int PROD_W     = 27;
    localparam int DRIVE_W    = 28;
    localparam int DUTY_W     = 10;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 18;

    // The duty field can never exceed this, whatever the parameter says.
    localparam int DUTY_HW_MAX = 1023;

    // Saturation limits of the encoder count.
    localparam logic [COUNT_W-1:0] COUNT_MIN = {1'b1, {(COUNT_W-1){1'b0}}};
    localparam logic [COUNT_W-1:0] COUNT_MAX = {1'b0, {(COUNT_W-1){1'b1}}};

    // Reset values of the configuration registers.
    localparam logic [GAIN_W-1:0]  PROP_GAIN_RST = 8'd1;
    localparam logic [GAIN_W-1:0]  INT_GAIN_RST  = 8'd0;
    localparam logic [INTEG_W-1:0] INTEG_MIN_RST = 18'h30000;
    localparam logic [IMAX_W-1:0]  INTEG_MAX_RST = 17'h0FFFF;

    // Input commands.
    typedef enum logic [CMD_W-1:0] {
        CMD_EDGE   = 2'd0,
        CMD_TICK   = 2'd1,
        CMD_TARGET = 2'd2,
        CMD_BRAKE  = 2'd3
    } t_cmd;

    // Configuration register indexes.
    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_PROP_GAIN = 2'd0,
        CFG_INT_GAIN  = 2'd1,
        CFG_INTEG_MIN = 2'd2,
        CFG_INTEG_MAX = 2'd3
    } t_cfg_idx;

    // What the output stage does with the duty and pin registers.
    typedef enum logic [1:0] {
        OP_HOLD  = 2'd0,
        OP_RUN   = 2'd1,
        OP_BRAKE = 2'd2
    } t_op;

    // Configuration register set.
    typedef struct packed {
        logic [GAIN_W-1:0]         prop_gain;
        logic [GAIN_W-1:0]         int_gain;
        logic signed [INTEG_W-1:0] integral_min;
        logic [IMAX_W-1:0]         integral_max;
    } t_cfg;

    // Control that travels with an item down the pipeline.
    typedef struct packed {
        t_op                       op;
        logic signed [COUNT_W-1:0] measured_ticks;
        logic                      brake_on;
    } t_ctl;

    // Item after the state update: speed error and clamped integral.
    typedef struct packed {
        t_ctl                      ctl;
        logic signed [ERR_W-1:0]   err;
        logic signed [INTEG_W-1:0] integ;
    } t_s2;

    // Item after the multipliers: proportional and integral terms.
    typedef struct packed {
        t_ctl                     ctl;
        logic signed [PROD_W-1:0] p_term;
        logic signed [PROD_W-1:0] i_term;
    } t_s3;

endpackage

@@ hdl/pims_item_if.sv @@
// Input channel interface: one command item per transfer.
interface pims_item_if;
    logic                              valid;
    logic                              ready;
    logic [pims_pkg::CMD_W-1:0]        cmd;
    logic                              channel_b;
    logic signed [pims_pkg::ARG_W-1:0] arg;

    modport source (output valid, cmd, channel_b, arg, input ready);
    modport sink (input valid, cmd, channel_b, arg, output ready);
endinterface

@@ hdl/pims_result_if.sv @@
// Output channel interface: one motor drive result per transfer.
interface pims_result_if;
    logic                                valid;
    logic                                ready;
    logic [pims_pkg::DUTY_W-1:0]         pwm_duty;
    logic                                dir_pin_a;
    logic                                dir_pin_b;
    logic signed [pims_pkg::COUNT_W-1:0] measured_ticks;
    logic                                brake_on;

    modport source (output valid, pwm_duty, dir_pin_a, dir_pin_b, measured_ticks, brake_on,
                    input ready);
    modport sink (input valid, pwm_duty, dir_pin_a, dir_pin_b, measured_ticks, brake_on,
                  output ready);
endinterface

@@ hdl/pims_state.sv @@
// Input register and loop state update: encoder count, target, brake and integral.
`include "assert_macros.svh"

module pims_state (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  pims_pkg::t_cfg                    i_cfg,
    input  logic                              i_valid,
    output logic                              o_ready,
    input  logic [pims_pkg::CMD_W-1:0]        i_cmd,
    input  logic                              i_channel_b,
    input  logic signed [pims_pkg::ARG_W-1:0] i_arg,
    output logic                              o_valid,
    input  logic                              i_ready,
    output pims_pkg::t_s2                     o_s2
);

    logic                                       r_s1_valid;
    pims_pkg::t_cmd                             r_s1_cmd;
    logic                                       r_s1_chb;
    logic signed [pims_pkg::ARG_W-1:0]          r_s1_arg;

    logic signed [pims_pkg::COUNT_W-1:0]        r_edge_count;
    logic signed [pims_pkg::COUNT_W-1:0]        r_latched;
    logic signed [pims_pkg::INTEG_W-1:0]        r_integral;
    logic signed [pims_pkg::ARG_W-1:0]          r_target;
    logic                                       r_brake;
    logic                                       r_s2_valid;
    pims_pkg::t_s2                              r_s2;

    logic signed [pims_pkg::COUNT_W-1:0]        n_edge_count;
    logic signed [pims_pkg::COUNT_W-1:0]        n_latched;
    logic signed [pims_pkg::INTEG_W-1:0]        n_integral;
    logic signed [pims_pkg::ARG_W-1:0]          n_target;
    logic                                       n_brake;
    pims_pkg::t_s2                              n_s2;

    logic                                       s2_ready;
    logic                                       adv;
    logic signed [pims_pkg::ERR_W-1:0]          err;
    logic signed [pims_pkg::ACC_W-1:0]          acc;
    logic signed [pims_pkg::ACC_W-1:0]          acc_lo;
    logic signed [pims_pkg::ACC_W-1:0]          lim_lo;
    logic signed [pims_pkg::ACC_W-1:0]          lim_hi;
    logic signed [pims_pkg::ACC_W-1:0]          clamped;

    // Handshake between the input register and the state stage.
    assign s2_ready = !r_s2_valid || i_ready;
    assign o_ready  = !r_s1_valid || s2_ready;
    assign adv      = r_s1_valid && s2_ready;
    assign o_valid  = r_s2_valid;
    assign o_s2     = r_s2;

    // Input register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else if (o_ready) begin
            r_s1_valid <= i_valid;
        end
        if (o_ready && i_valid) begin
            r_s1_cmd <= pims_pkg::t_cmd'(i_cmd);
            r_s1_chb <= i_channel_b;
            r_s1_arg <= i_arg;
        end
    end

    // Speed error and the integral with its clamps, lower clamp first.
    always_comb begin
        err = {{(pims_pkg::ERR_W-pims_pkg::ARG_W){r_target[pims_pkg::ARG_W-1]}}, r_target}
            - {{(pims_pkg::ERR_W-pims_pkg::COUNT_W){r_edge_count[pims_pkg::COUNT_W-1]}},
               r_edge_count};
        acc = {{(pims_pkg::ACC_W-pims_pkg::INTEG_W){r_integral[pims_pkg::INTEG_W-1]}},
               r_integral}
            + {{(pims_pkg::ACC_W-pims_pkg::ERR_W){err[pims_pkg::ERR_W-1]}}, err};
        lim_lo = {{(pims_pkg::ACC_W-pims_pkg::INTEG_W){i_cfg.integral_min[pims_pkg::INTEG_W-1]}},
                  i_cfg.integral_min};
        lim_hi = {{(pims_pkg::ACC_W-pims_pkg::IMAX_W){1'b0}}, i_cfg.integral_max};
        acc_lo  = (acc < lim_lo) ? lim_lo : acc;
        clamped = (acc_lo > lim_hi) ? lim_hi : acc_lo;
    end

    // Command decode and next state.
    always_comb begin
        n_edge_count = r_edge_count;
        n_latched    = r_latched;
        n_integral   = r_integral;
        n_target     = r_target;
        n_brake      = r_brake;
        n_s2.ctl.op  = pims_pkg::OP_HOLD;
        unique case (r_s1_cmd)
            pims_pkg::CMD_EDGE: begin
                if (r_s1_chb) begin
                    if (r_edge_count != pims_pkg::COUNT_MIN) begin
                        n_edge_count = r_edge_count - pims_pkg::COUNT_W'(1);
                    end
                end else if (r_edge_count != pims_pkg::COUNT_MAX) begin
                    n_edge_count = r_edge_count + pims_pkg::COUNT_W'(1);
                end
            end
            pims_pkg::CMD_TICK: begin
                n_latched    = r_edge_count;
                n_edge_count = '0;
                if (r_brake) begin
                    n_integral  = '0;
                    n_s2.ctl.op = pims_pkg::OP_BRAKE;
                end else begin
                    n_integral  = clamped[pims_pkg::INTEG_W-1:0];
                    n_s2.ctl.op = pims_pkg::OP_RUN;
                end
            end
            pims_pkg::CMD_TARGET: begin
                n_target = r_s1_arg;
            end
            pims_pkg::CMD_BRAKE: begin
                n_brake = r_s1_arg[0];
                if (r_s1_arg[0]) begin
                    n_integral  = '0;
                    n_s2.ctl.op = pims_pkg::OP_BRAKE;
                end
            end
            default: begin
            end
        endcase
        n_s2.ctl.measured_ticks = n_latched;
        n_s2.ctl.brake_on       = n_brake;
        n_s2.err                = err;
        n_s2.integ              = n_integral;
    end

    // Loop state and the state stage register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_edge_count <= '0;
            r_latched    <= '0;
            r_integral   <= '0;
            r_target     <= '0;
            r_brake      <= 1'b0;
            r_s2_valid   <= 1'b0;
        end else begin
            if (adv) begin
                r_edge_count <= n_edge_count;
                r_latched    <= n_latched;
                r_integral   <= n_integral;
                r_target     <= n_target;
                r_brake      <= n_brake;
            end
            if (s2_ready) begin
                r_s2_valid <= r_s1_valid;
            end
        end
        if (adv) begin
            r_s2 <= n_s2;
        end
    end

    // A control tick always leaves the encoder count cleared.
    `PIMS_ASSERT_NEXT(a_tick_clears_count, adv && r_s1_cmd == pims_pkg::CMD_TICK, r_edge_count == '0, "count not cleared by tick")
    // While the brake is on, the integral stays cleared.
    `PIMS_ASSERT_SAME(a_brake_integral, r_brake, r_integral == '0, "integral nonzero under brake")
    // A braking item in flight implies a cleared integral.
    `PIMS_ASSERT_SAME(a_brake_op_integral, r_s2_valid && r_s2.ctl.op == pims_pkg::OP_BRAKE, r_integral == '0, "brake op with nonzero integral")

endmodule

@@ hdl/pims_mult.sv @@
// Multiplier stage: proportional and integral terms of the drive.
module pims_mult (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  pims_pkg::t_cfg i_cfg,
    input  logic          i_valid,
    output logic          o_ready,
    input  pims_pkg::t_s2 i_s2,
    output logic          o_valid,
    input  logic          i_ready,
    output pims_pkg::t_s3 o_s3
);

    logic                                  r_valid;
    pims_pkg::t_s3                         r_s3;
    pims_pkg::t_s3                         n_s3;
    logic signed [pims_pkg::PROD_W-1:0]    kp_x;
    logic signed [pims_pkg::PROD_W-1:0]    ki_x;
    logic signed [pims_pkg::PROD_W-1:0]    err_x;
    logic signed [pims_pkg::PROD_W-1:0]    integ_x;

    assign o_ready = !r_valid || i_ready;
    assign o_valid = r_valid;
    assign o_s3    = r_s3;

    // Gains are unsigned; both products fit the term width.
    always_comb begin
        kp_x    = {{(pims_pkg::PROD_W-pims_pkg::GAIN_W){1'b0}}, i_cfg.prop_gain};
        ki_x    = {{(pims_pkg::PROD_W-pims_pkg::GAIN_W){1'b0}}, i_cfg.int_gain};
        err_x   = {{(pims_pkg::PROD_W-pims_pkg::ERR_W){i_s2.err[pims_pkg::ERR_W-1]}}, i_s2.err};
        integ_x = {{(pims_pkg::PROD_W-pims_pkg::INTEG_W){i_s2.integ[pims_pkg::INTEG_W-1]}},
                   i_s2.integ};
        n_s3.ctl    = i_s2.ctl;
        n_s3.p_term = kp_x * err_x;
        n_s3.i_term = ki_x * integ_x;
    end

    // Term register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_valid;
        end
        if (o_ready && i_valid) begin
            r_s3 <= n_s3;
        end
    end

endmodule

@@ hdl/pims_drive.sv @@
// Output stage: drive sum, direction and duty limit, and the result register.
`include "assert_macros.svh"

module pims_drive #(
    parameter int DUTY_MAX = 1023
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_valid,
    output logic                                o_ready,
    input  pims_pkg::t_s3                       i_s3,
    output logic                                o_valid,
    input  logic                                i_ready,
    output logic [pims_pkg::DUTY_W-1:0]         o_pwm_duty,
    output logic                                o_dir_pin_a,
    output logic                                o_dir_pin_b,
    output logic signed [pims_pkg::COUNT_W-1:0] o_measured_ticks,
    output logic                                o_brake_on
);

    localparam int DutyLimit = (DUTY_MAX < pims_pkg::DUTY_HW_MAX) ? DUTY_MAX
                                                                  : pims_pkg::DUTY_HW_MAX;

    logic                                 r_out_valid;
    logic [pims_pkg::DUTY_W-1:0]          r_duty;
    logic [1:0]                           r_pins;
    logic signed [pims_pkg::COUNT_W-1:0]  r_out_ticks;
    logic                                 r_out_brake;
    logic [pims_pkg::DUTY_W-1:0]          n_duty;
    logic [1:0]                           n_pins;

    logic                                 adv;
    logic signed [pims_pkg::DRIVE_W-1:0]  drive;
    logic [pims_pkg::DRIVE_W-1:0]         mag;
    logic                                 dir;
    logic [pims_pkg::DUTY_W-1:0]          duty_sat;

    assign o_ready = !r_out_valid || i_ready;
    assign adv     = o_ready && i_valid;

    // Drive sum, its sign and its limited magnitude.
    always_comb begin
        drive = {i_s3.p_term[pims_pkg::PROD_W-1], i_s3.p_term}
              + {i_s3.i_term[pims_pkg::PROD_W-1], i_s3.i_term};
        dir   = !drive[pims_pkg::DRIVE_W-1] && (drive != '0);
        mag   = drive[pims_pkg::DRIVE_W-1] ? unsigned'(-drive) : unsigned'(drive);
        duty_sat = (mag > pims_pkg::DRIVE_W'(DutyLimit)) ? pims_pkg::DUTY_W'(DutyLimit)
                                                          : mag[pims_pkg::DUTY_W-1:0];
    end

    // Duty and pin update; in run, pin b follows the direction and pin a its inverse; brake sets both.
    always_comb begin
        n_duty = r_duty;
        n_pins = r_pins;
        case (i_s3.ctl.op)
            pims_pkg::OP_RUN: begin
                n_duty = duty_sat;
                n_pins = {dir, !dir};
            end
            pims_pkg::OP_BRAKE: begin
                n_duty = '0;
                n_pins = 2'b11;
            end
            default: begin
            end
        endcase
    end

    // Drive state and result register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
            r_duty      <= '0;
            r_pins      <= 2'b00;
        end else begin
            if (o_ready) begin
                r_out_valid <= i_valid;
            end
            if (adv) begin
                r_duty <= n_duty;
                r_pins <= n_pins;
            end
        end
        if (adv) begin
            r_out_ticks <= i_s3.ctl.measured_ticks;
            r_out_brake <= i_s3.ctl.brake_on;
        end
    end

    assign o_valid          = r_out_valid;
    assign o_pwm_duty       = r_duty;
    assign o_dir_pin_a      = r_pins[0];
    assign o_dir_pin_b      = r_pins[1];
    assign o_measured_ticks = r_out_ticks;
    assign o_brake_on       = r_out_brake;

    // A result with the brake on shows zero duty and both pins high.
    `PIMS_ASSERT_SAME(a_brake_outputs, r_out_valid && r_out_brake, r_duty == '0 && r_pins == 2'b11, "brake result not zero duty with pins high")
    // Both pins low only before the first tick, when the duty is still zero.
    `PIMS_ASSERT_SAME(a_idle_pins_duty, r_pins == 2'b00, r_duty == '0, "duty set while pins idle")
    // The duty register never passes its limit.
    `PIMS_ASSERT_SAME(a_duty_limit, 1'b1, r_duty <= pims_pkg::DUTY_W'(DutyLimit), "duty above limit")

endmodule

@@ hdl/encoder_pi_motor_speed_loop.sv @@
// Top level of the encoder-fed PI motor speed loop with its configuration registers.
//
// Use: commands arrive on i_item (encoder edge with channel B level, control tick,
// set target, set brake), one per transfer. Every command yields exactly one result
// transfer on o_result: PWM duty, both H-bridge direction pins, the count latched at
// the last tick and the brake flag, all as they stand after that command.
// Configuration registers (gains and integral clamps) are written through i_cfg_we,
// i_cfg_idx and i_cfg_data (indexes 0 to 3 select them); the user must write them
// only while the loop is idle, as the block does not enforce it. Commands pass the
// input register, state update stage, multiplier stage and result register in that order.
// Throughput: one command per cycle while o_result is ready; the state update of one
// command sits in a single stage, so the next command sees it without any wait.
// Reset: synchronous and active low; the count, integral, target, brake, duty and
// pins clear, and the registers take their defaults (proportional gain 1,
// integral gain 0, clamps -65536 and 65535).
// Stall: when o_result is not ready the stages fill one by one, so up to four
// commands are taken before i_item.ready drops; no result is lost or repeated.
module encoder_pi_motor_speed_loop #(
    parameter int DUTY_MAX = 1023
) (
    input  logic                                   i_clk,
    input  logic                                   i_rst_n,
    pims_item_if.sink                              i_item,
    pims_result_if.source                          o_result,
    input  logic                                   i_cfg_we,
    input  logic [pims_pkg::CFG_IDX_W-1:0]         i_cfg_idx,
    input  logic [pims_pkg::CFG_DATA_W-1:0]        i_cfg_data
);

    pims_pkg::t_cfg r_cfg;
    logic           s2_valid;
    logic           s2_ready;
    pims_pkg::t_s2  s2;
    logic           s3_valid;
    logic           s3_ready;
    pims_pkg::t_s3  s3;

    // Configuration register writes.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.prop_gain    <= pims_pkg::PROP_GAIN_RST;
            r_cfg.int_gain     <= pims_pkg::INT_GAIN_RST;
            r_cfg.integral_min <= pims_pkg::INTEG_MIN_RST;
            r_cfg.integral_max <= pims_pkg::INTEG_MAX_RST;
        end else if (i_cfg_we) begin
            unique case (pims_pkg::t_cfg_idx'(i_cfg_idx))
                pims_pkg::CFG_PROP_GAIN: r_cfg.prop_gain <= i_cfg_data[pims_pkg::GAIN_W-1:0];
                pims_pkg::CFG_INT_GAIN:  r_cfg.int_gain  <= i_cfg_data[pims_pkg::GAIN_W-1:0];
                pims_pkg::CFG_INTEG_MIN: r_cfg.integral_min <= i_cfg_data;
                pims_pkg::CFG_INTEG_MAX: begin
                    r_cfg.integral_max <= i_cfg_data[pims_pkg::IMAX_W-1:0];
                end
                default: begin
                end
            endcase
        end
    end

    // Input register and state update.
    pims_state u_state (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg       (r_cfg),
        .i_valid     (i_item.valid),
        .o_ready     (i_item.ready),
        .i_cmd       (i_item.cmd),
        .i_channel_b (i_item.channel_b),
        .i_arg       (i_item.arg),
        .o_valid     (s2_valid),
        .i_ready     (s2_ready),
        .o_s2        (s2)
    );

    // Proportional and integral products.
    pims_mult u_mult (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cfg   (r_cfg),
        .i_valid (s2_valid),
        .o_ready (s2_ready),
        .i_s2    (s2),
        .o_valid (s3_valid),
        .i_ready (s3_ready),
        .o_s3    (s3)
    );

    // Drive, duty and pins, and the result register.
    pims_drive #(
        .DUTY_MAX (DUTY_MAX)
    ) u_drive (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_valid          (s3_valid),
        .o_ready          (s3_ready),
        .i_s3             (s3),
        .o_valid          (o_result.valid),
        .i_ready          (o_result.ready),
        .o_pwm_duty       (o_result.pwm_duty),
        .o_dir_pin_a      (o_result.dir_pin_a),
        .o_dir_pin_b      (o_result.dir_pin_b),
        .o_measured_ticks (o_result.measured_ticks),
        .o_brake_on       (o_result.brake_on)
    );

endmodule
